// ===== sv/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, field widths, operation codes and controller/datapath command
// encodings for the indexed stack list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 5;
  localparam int IDX2_W  = 4;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_SWAP   = 3'd5;
  localparam logic [OP_W-1:0] OP_GET    = 3'd6;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd7;

  // read address select
  localparam logic [1:0] RA_IDX    = 2'd0;
  localparam logic [1:0] RA_IDX2   = 2'd1;
  localparam logic [1:0] RA_PTR_DN = 2'd2;
  localparam logic [1:0] RA_PTR_UP = 2'd3;

  // write address and data select
  localparam logic [2:0] WA_FILL_DATA = 3'd0;
  localparam logic [2:0] WA_PTR_RD    = 3'd1;
  localparam logic [2:0] WA_IDX_DATA  = 3'd2;
  localparam logic [2:0] WA_IDX_RD    = 3'd3;
  localparam logic [2:0] WA_IDX2_TMP  = 3'd4;

  // pointer update
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_FILL = 3'd1;
  localparam logic [2:0] PTR_IDX  = 3'd2;
  localparam logic [2:0] PTR_DEC  = 3'd3;
  localparam logic [2:0] PTR_INC  = 3'd4;

  // fill update
  localparam logic [1:0] FILL_HOLD = 2'd0;
  localparam logic [1:0] FILL_INC  = 2'd1;
  localparam logic [1:0] FILL_DEC  = 2'd2;
  localparam logic [1:0] FILL_CLR  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  index;
    logic [IDX2_W-1:0] second_index;
    logic [WORD_W-1:0] data_in;
  } request_t;

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  data_out;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [2:0] wr_sel;
    logic [2:0] ptr_op;
    logic [1:0] fill_op;
    logic       tmp_ld;
    logic       finish;
    logic       finish_ok;
    logic       finish_rd;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            legal;
    logic            ptr_at_idx;
    logic            rem_last;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/isl_ctrl.sv =====
// ----------------------------------------------------------------------------
// isl_ctrl
// Request sequencer: decodes the latched request and steps the datapath
// through reads, writes and entry shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire isl_pkg::status_t status,
  output isl_pkg::cmd_t         cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_GET_OUT = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_REM_CHK = 4'd5;
  localparam logic [3:0] S_REM_WR  = 4'd6;
  localparam logic [3:0] S_SWP_RB  = 4'd7;
  localparam logic [3:0] S_SWP_WA  = 4'd8;
  localparam logic [3:0] S_SWP_WB  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.legal) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          case (status.op)
            isl_pkg::OP_PUSH: begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = isl_pkg::WA_FILL_DATA;
              cmd.fill_op   = isl_pkg::FILL_INC;
              cmd.finish    = 1'b1;
              cmd.finish_ok = 1'b1;
              state_next    = S_IDLE;
            end
            isl_pkg::OP_POP: begin
              cmd.fill_op   = isl_pkg::FILL_DEC;
              cmd.finish    = 1'b1;
              cmd.finish_ok = 1'b1;
              state_next    = S_IDLE;
            end
            isl_pkg::OP_CLEAR: begin
              cmd.fill_op   = isl_pkg::FILL_CLR;
              cmd.finish    = 1'b1;
              cmd.finish_ok = 1'b1;
              state_next    = S_IDLE;
            end
            isl_pkg::OP_INSERT: begin
              cmd.ptr_op = isl_pkg::PTR_FILL;
              state_next = S_INS_CHK;
            end
            isl_pkg::OP_REMOVE: begin
              cmd.ptr_op = isl_pkg::PTR_IDX;
              state_next = S_REM_CHK;
            end
            isl_pkg::OP_SWAP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isl_pkg::RA_IDX;
              state_next = S_SWP_RB;
            end
            isl_pkg::OP_GET: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = isl_pkg::RA_IDX;
              state_next = S_GET_OUT;
            end
            default: begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = isl_pkg::WA_IDX_DATA;
              cmd.finish    = 1'b1;
              cmd.finish_ok = 1'b1;
              state_next    = S_IDLE;
            end
          endcase
        end
      end
      S_GET_OUT: begin
        cmd.finish    = 1'b1;
        cmd.finish_ok = 1'b1;
        cmd.finish_rd = 1'b1;
        state_next    = S_IDLE;
      end
      S_INS_CHK: begin
        if (status.ptr_at_idx) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = isl_pkg::WA_IDX_DATA;
          cmd.fill_op   = isl_pkg::FILL_INC;
          cmd.finish    = 1'b1;
          cmd.finish_ok = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isl_pkg::RA_PTR_DN;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = isl_pkg::WA_PTR_RD;
        cmd.ptr_op = isl_pkg::PTR_DEC;
        state_next = S_INS_CHK;
      end
      S_REM_CHK: begin
        if (status.rem_last) begin
          cmd.fill_op   = isl_pkg::FILL_DEC;
          cmd.finish    = 1'b1;
          cmd.finish_ok = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isl_pkg::RA_PTR_UP;
          state_next = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = isl_pkg::WA_PTR_RD;
        cmd.ptr_op = isl_pkg::PTR_INC;
        state_next = S_REM_CHK;
      end
      S_SWP_RB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = isl_pkg::RA_IDX2;
        cmd.tmp_ld = 1'b1;
        state_next = S_SWP_WA;
      end
      S_SWP_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = isl_pkg::WA_IDX_RD;
        state_next = S_SWP_WB;
      end
      S_SWP_WB: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = isl_pkg::WA_IDX2_TMP;
        cmd.finish    = 1'b1;
        cmd.finish_ok = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/isl_datapath.sv =====
// ----------------------------------------------------------------------------
// isl_datapath
// Entry memory, fill count, shift pointer, request latch and result register
// for the indexed stack list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isl_datapath #(
  parameter int DEPTH  = isl_pkg::DEPTH_DEF,
  parameter int DATA_W = isl_pkg::DATA_W_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire isl_pkg::request_t request,
  input  wire isl_pkg::cmd_t     cmd,
  output isl_pkg::status_t       status,
  output logic                   done,
  output isl_pkg::result_t       result
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > isl_pkg::IDX_W) ? CW : isl_pkg::IDX_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [isl_pkg::OP_W-1:0]   op;
  logic [isl_pkg::IDX_W-1:0]  idx;
  logic [isl_pkg::IDX2_W-1:0] idx2;
  logic [DATA_W-1:0]          data;
  logic [DATA_W-1:0]          rdata;
  logic [DATA_W-1:0]          tmp;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_next;
  logic [CW-1:0]              ptr;
  logic [CW-1:0]              ptr_dn;
  logic [CW-1:0]              ptr_up;

  logic [CMPW-1:0]   idx_x;
  logic [CMPW-1:0]   idx2_x;
  logic [CMPW-1:0]   fill_x;
  logic              not_full;
  logic              not_empty;
  logic              idx_in;
  logic              idx2_in;
  logic              legal;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  assign idx_x     = CMPW'(idx);
  assign idx2_x    = CMPW'(idx2);
  assign fill_x    = CMPW'(fill);
  assign not_full  = (fill < CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign idx_in    = (idx_x < fill_x);
  assign idx2_in   = (idx2_x < fill_x);
  assign ptr_dn    = ptr - CW'(1);
  assign ptr_up    = ptr + CW'(1);

  always_comb begin
    case (op)
      isl_pkg::OP_PUSH:   legal = not_full;
      isl_pkg::OP_POP:    legal = not_empty;
      isl_pkg::OP_CLEAR:  legal = 1'b1;
      isl_pkg::OP_INSERT: legal = (idx_x <= fill_x) && not_full;
      isl_pkg::OP_SWAP:   legal = idx_in && idx2_in;
      default:            legal = idx_in;
    endcase
  end

  assign status.legal      = legal;
  assign status.op         = op;
  assign status.ptr_at_idx = (CMPW'(ptr) == idx_x);
  assign status.rem_last   = (ptr_up >= fill);

  always_comb begin
    case (cmd.rd_sel)
      isl_pkg::RA_IDX:    raddr = idx_x[AW-1:0];
      isl_pkg::RA_IDX2:   raddr = idx2_x[AW-1:0];
      isl_pkg::RA_PTR_DN: raddr = ptr_dn[AW-1:0];
      default:            raddr = ptr_up[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      isl_pkg::WA_FILL_DATA: begin
        waddr = fill[AW-1:0];
        wdata = data;
      end
      isl_pkg::WA_PTR_RD: begin
        waddr = ptr[AW-1:0];
        wdata = rdata;
      end
      isl_pkg::WA_IDX_DATA: begin
        waddr = idx_x[AW-1:0];
        wdata = data;
      end
      isl_pkg::WA_IDX_RD: begin
        waddr = idx_x[AW-1:0];
        wdata = rdata;
      end
      isl_pkg::WA_IDX2_TMP: begin
        waddr = idx2_x[AW-1:0];
        wdata = tmp;
      end
      default: begin
        waddr = '0;
        wdata = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.fill_op)
      isl_pkg::FILL_INC: fill_next = fill + CW'(1);
      isl_pkg::FILL_DEC: fill_next = fill - CW'(1);
      isl_pkg::FILL_CLR: fill_next = '0;
      default:           fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= request.operation;
      idx  <= request.index;
      idx2 <= request.second_index;
      data <= DATA_W'(request.data_in);
    end
    if (cmd.tmp_ld) begin
      tmp <= rdata;
    end
    case (cmd.ptr_op)
      isl_pkg::PTR_FILL: ptr <= fill;
      isl_pkg::PTR_IDX:  ptr <= idx_x[CW-1:0];
      isl_pkg::PTR_DEC:  ptr <= ptr_dn;
      isl_pkg::PTR_INC:  ptr <= ptr_up;
      default:           ptr <= ptr;
    endcase
    if (cmd.finish) begin
      result.ok       <= cmd.finish_ok;
      result.data_out <= cmd.finish_rd ? isl_pkg::WORD_W'(rdata) : '0;
      result.count    <= isl_pkg::COUNT_W'(fill_next);
    end
  end

endmodule

`default_nettype wire

// ===== sv/indexed_stack_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_stack_list_core
// Bounded ordered list with a stack on top: push, pop, clear, insert, remove,
// swap, get and update on a single-port entry memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off, so
// the receiver must take it then. Push, pop, clear, update and any rejected
// request finish in the decode state; get adds an output state, and swap
// reads both entries, then writes each into the other's place. Insert and
// remove walk the single-port entry memory one entry at a time, a read then
// a write per entry; insert moves count - index entries, remove count - index - 1.
`timescale 1ns / 1ps
`default_nettype none

module indexed_stack_list_core #(
  parameter int DEPTH  = isl_pkg::DEPTH_DEF,
  parameter int DATA_W = isl_pkg::DATA_W_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire isl_pkg::request_t request,
  output logic                   done,
  output isl_pkg::result_t       result
);

  isl_pkg::cmd_t    cmd;
  isl_pkg::status_t status;

  isl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  isl_datapath #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule

`default_nettype wire
